[src/rmrv_pkg.sv]
// Shared constants and types for the rotation matrix unit.
`default_nettype none

package rmrv_pkg;

	// Default fraction bits of the quaternion and matrix fixed-point format.
	localparam int FRAC_BITS_DEF = 14;

	// Width of every input and output field.
	localparam int DATA_W = 16;

	// Vector part of the quaternion, carried alongside the square root pipeline.
	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
	} vec_t;

endpackage

`default_nettype wire

[src/rmrv_isqrt.sv]
// Pipelined floor integer square root, one result bit per stage.
`default_nettype none

module rmrv_isqrt #(
	parameter int FRAC_BITS = rmrv_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rad_vld,
	input  wire logic [2*FRAC_BITS+1:0]        rad,
	input  wire rmrv_pkg::vec_t                rad_vec,
	output logic                               root_vld,
	output logic [FRAC_BITS:0]                 root,
	output rmrv_pkg::vec_t                     root_vec
);

	// Radicand width and root width; the radicand never exceeds 2^(2*FRAC_BITS).
	localparam int SW = 2 * FRAC_BITS + 2;
	localparam int RW = FRAC_BITS + 1;

	logic           vld_s  [RW];
	logic [SW-1:0]  rem_s  [RW];
	logic [RW-1:0]  root_s [RW];
	rmrv_pkg::vec_t vec_s  [RW];

	logic [SW-1:0]  rem_in  [RW];
	logic [RW-1:0]  root_in [RW];
	logic           vld_in  [RW];
	rmrv_pkg::vec_t vec_in  [RW];
	logic [SW-1:0]  trial   [RW];

	// Select each stage's operands and form the trial term (2*root + 2^b) * 2^b.
	always_comb begin
		for (int k = 0; k < RW; k++) begin
			if (k == 0) begin
				rem_in[k]  = rad;
				root_in[k] = '0;
				vld_in[k]  = rad_vld;
				vec_in[k]  = rad_vec;
			end else begin
				rem_in[k]  = rem_s[k-1];
				root_in[k] = root_s[k-1];
				vld_in[k]  = vld_s[k-1];
				vec_in[k]  = vec_s[k-1];
			end
			trial[k] = (SW'(root_in[k]) << (FRAC_BITS - k + 1))
				| (SW'(1) << (2 * (FRAC_BITS - k)));
		end
	end

	// Advance the valid bits every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RW; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < RW; k++) begin
				vld_s[k] <= vld_in[k];
			end
		end
	end

	// Decide one root bit per stage; keep the remainder as radicand minus root squared.
	always_ff @(posedge clk) begin
		for (int k = 0; k < RW; k++) begin
			vec_s[k] <= vec_in[k];
			if (rem_in[k] >= trial[k]) begin
				rem_s[k]  <= rem_in[k] - trial[k];
				root_s[k] <= root_in[k] | (RW'(1) << (FRAC_BITS - k));
			end else begin
				rem_s[k]  <= rem_in[k];
				root_s[k] <= root_in[k];
			end
		end
	end

	assign root_vld = vld_s[RW-1];
	assign root     = root_s[RW-1];
	assign root_vec = vec_s[RW-1];

	// Every input valid leaves through the chain of stage valid registers, one register per result bit.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		rad_vld |-> ##RW root_vld)
		else $error("square root valid does not match its input delay");

	// No output valid without a matching input that passed through every stage.
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		root_vld |-> $past(rad_vld, RW))
		else $error("square root valid without a matching input");

	// Floor property: the leftover remainder is at most twice the root.
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		root_vld |-> (rem_s[RW-1] <= (SW'(root) << 1)))
		else $error("square root remainder too large");

	// The root of a radicand bounded by one never exceeds one.
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		root_vld |-> (root <= (RW'(1) << FRAC_BITS)))
		else $error("square root exceeds one");

endmodule

`default_nettype wire

[src/rotation_matrix_from_rotation_vector_unit.sv]
// Top level: 3x3 rotation matrix from the vector part of a unit quaternion.
// Throughput: one item per cycle when not busy; squares, bit-per-stage root and products all pipeline.
// The square root takes FRAC_BITS+1 stages and sets most of the latency.
// busy is high only during reset and the cycle after it; results cannot be stalled.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
`default_nettype none

module rotation_matrix_from_rotation_vector_unit #(
	parameter int FRAC_BITS = rmrv_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [rmrv_pkg::DATA_W-1:0]   qx,
	input  wire logic signed [rmrv_pkg::DATA_W-1:0]   qy,
	input  wire logic signed [rmrv_pkg::DATA_W-1:0]   qz,
	output logic                                      done,
	output logic signed [rmrv_pkg::DATA_W-1:0]        m00,
	output logic signed [rmrv_pkg::DATA_W-1:0]        m01,
	output logic signed [rmrv_pkg::DATA_W-1:0]        m02,
	output logic signed [rmrv_pkg::DATA_W-1:0]        m10,
	output logic signed [rmrv_pkg::DATA_W-1:0]        m11,
	output logic signed [rmrv_pkg::DATA_W-1:0]        m12,
	output logic signed [rmrv_pkg::DATA_W-1:0]        m20,
	output logic signed [rmrv_pkg::DATA_W-1:0]        m21,
	output logic signed [rmrv_pkg::DATA_W-1:0]        m22
);

	localparam int DW_ = rmrv_pkg::DATA_W;
	localparam int SQW = 2 * DW_;
	localparam int SW  = 2 * FRAC_BITS + 2;
	localparam int RW  = FRAC_BITS + 1;
	localparam int WXW = DW_ + RW + 1;
	// Width for one minus the squared norm.
	localparam int DW  = ((2 * FRAC_BITS + 1 > SQW) ? 2 * FRAC_BITS + 1 : SQW) + 2;
	// Width for the exact matrix entry sums.
	localparam int EB0 = (2 * FRAC_BITS + 1 > SQW) ? 2 * FRAC_BITS + 1 : SQW;
	localparam int EW  = ((EB0 > WXW) ? EB0 : WXW) + 3;
	localparam int LAT = FRAC_BITS + 5;

	localparam logic signed [DW-1:0] ONE2D = DW'(1) << (2 * FRAC_BITS);
	localparam logic signed [EW-1:0] ONE2E = EW'(1) << (2 * FRAC_BITS);

	logic busy_q;
	logic accept;

	// Hold busy through reset and release it at the next clock edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	// Stage 1: squares of the vector part.
	logic                   vld_s1;
	rmrv_pkg::vec_t         vec_s1;
	logic signed [SQW-1:0]  xx_s1, yy_s1, zz_s1;

	// Stage 2: one minus the squared norm, clamped at zero.
	logic                   vld_s2;
	rmrv_pkg::vec_t         vec_s2;
	logic [SW-1:0]          rest_s2;
	logic signed [DW-1:0]   diff;

	always_comb begin
		diff = ONE2D - DW'(xx_s1) - DW'(yy_s1) - DW'(zz_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= '{x: qx, y: qy, z: qz};
		xx_s1  <= SQW'(qx) * SQW'(qx);
		yy_s1  <= SQW'(qy) * SQW'(qy);
		zz_s1  <= SQW'(qz) * SQW'(qz);
		vec_s2 <= vec_s1;
		if (!diff[DW-1] && (diff != '0)) begin
			rest_s2 <= SW'(diff);
		end else begin
			rest_s2 <= '0;
		end
	end

	// Rebuild the scalar part w.
	logic                   w_vld;
	logic [RW-1:0]          w_root;
	rmrv_pkg::vec_t         w_vec;

	rmrv_isqrt #(
		.FRAC_BITS (FRAC_BITS)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.rad_vld  (vld_s2),
		.rad      (rest_s2),
		.rad_vec  (vec_s2),
		.root_vld (w_vld),
		.root     (w_root),
		.root_vec (w_vec)
	);

	// Stage 3: squares and pairwise products of x, y and z, and their products with w.
	logic                   vld_s3;
	logic signed [SQW-1:0]  xx_s3, yy_s3, zz_s3, xy_s3, xz_s3, yz_s3;
	logic signed [WXW-1:0]  xw_s3, yw_s3, zw_s3;
	logic signed [RW:0]     w_sgn;

	assign w_sgn = signed'({1'b0, w_root});

	always_ff @(posedge clk) begin
		xx_s3 <= SQW'(w_vec.x) * SQW'(w_vec.x);
		yy_s3 <= SQW'(w_vec.y) * SQW'(w_vec.y);
		zz_s3 <= SQW'(w_vec.z) * SQW'(w_vec.z);
		xy_s3 <= SQW'(w_vec.x) * SQW'(w_vec.y);
		xz_s3 <= SQW'(w_vec.x) * SQW'(w_vec.z);
		yz_s3 <= SQW'(w_vec.y) * SQW'(w_vec.z);
		xw_s3 <= WXW'(w_vec.x) * WXW'(w_sgn);
		yw_s3 <= WXW'(w_vec.y) * WXW'(w_sgn);
		zw_s3 <= WXW'(w_vec.z) * WXW'(w_sgn);
	end

	// Stage 4: exact entry sums, row-major order m00 .. m22.
	logic                   vld_s4;
	logic signed [EW-1:0]   sum_s4 [9];

	always_ff @(posedge clk) begin
		sum_s4[0] <= ONE2E - (EW'(yy_s3) << 1) - (EW'(zz_s3) << 1);
		sum_s4[1] <= (EW'(xy_s3) << 1) - (EW'(zw_s3) << 1);
		sum_s4[2] <= (EW'(xz_s3) << 1) + (EW'(yw_s3) << 1);
		sum_s4[3] <= (EW'(xy_s3) << 1) + (EW'(zw_s3) << 1);
		sum_s4[4] <= ONE2E - (EW'(xx_s3) << 1) - (EW'(zz_s3) << 1);
		sum_s4[5] <= (EW'(yz_s3) << 1) - (EW'(xw_s3) << 1);
		sum_s4[6] <= (EW'(xz_s3) << 1) - (EW'(yw_s3) << 1);
		sum_s4[7] <= (EW'(yz_s3) << 1) + (EW'(xw_s3) << 1);
		sum_s4[8] <= ONE2E - (EW'(xx_s3) << 1) - (EW'(yy_s3) << 1);
	end

	// Stage 5: floor shift and saturate to the output width.
	logic                   vld_s5;
	logic signed [DW_-1:0]  m_s5 [9];
	logic signed [EW-1:0]   sh   [9];
	logic signed [DW_-1:0]  fin  [9];

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			sh[k] = sum_s4[k] >>> FRAC_BITS;
			if ((&sh[k][EW-1:DW_-1]) || !(|sh[k][EW-1:DW_-1])) begin
				fin[k] = sh[k][DW_-1:0];
			end else if (sh[k][EW-1]) begin
				fin[k] = {1'b1, {(DW_-1){1'b0}}};
			end else begin
				fin[k] = {1'b0, {(DW_-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			m_s5[k] <= fin[k];
		end
	end

	// Advance the valid bits of the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s3 <= w_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign done = vld_s5;
	assign m00  = m_s5[0];
	assign m01  = m_s5[1];
	assign m02  = m_s5[2];
	assign m10  = m_s5[3];
	assign m11  = m_s5[4];
	assign m12  = m_s5[5];
	assign m20  = m_s5[6];
	assign m21  = m_s5[7];
	assign m22  = m_s5[8];

	// Every accepted item raises the result strobe after passing through every pipeline stage.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(LAT + 1) done)
		else $error("accepted item gives no result strobe");

	// No result strobe without a matching accepted item.
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT + 1))
		else $error("result strobe without an accepted item");

	// A zero vector part gives zero m01, m10 and m12 and equal diagonal entries.
	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(accept && (qx == '0) && (qy == '0) && (qz == '0), LAT + 1))
		|-> (m01 == '0 && m10 == '0 && m12 == '0 && m00 == m11 && m11 == m22))
		else $error("zero rotation does not give a scaled identity");

	// No item is taken while busy is high.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !vld_s1)
		else $error("item entered the pipeline while busy");

endmodule

`default_nettype wire

[tb/rotation_matrix_from_rotation_vector_unit_tb.sv]
// Testbench for the quaternion vector part to 3x3 rotation matrix unit.
`default_nettype none

module rotation_matrix_from_rotation_vector_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = rmrv_pkg::FRAC_BITS_DEF;
	localparam int W = rmrv_pkg::DATA_W;
	localparam longint UNIT_SQ = longint'(1) <<< (2 * FRAC);
	localparam int ONE = 1 << FRAC;
	localparam int SETTLE_CYCLES = FRAC + 12;

	// Nine matrix entries, entry 0 is m00 and entry 8 is m22 (row major)
	typedef logic [8:0][W-1:0] mat_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [W-1:0] qx, qy, qz;
	logic done;
	logic signed [W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	mat_t expected_mats[$];
	int errors;
	string entry_name [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

	rotation_matrix_from_rotation_vector_unit u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.qx    (qx),
		.qy    (qy),
		.qz    (qz),
		.done  (done),
		.m00   (m00),
		.m01   (m01),
		.m02   (m02),
		.m10   (m10),
		.m11   (m11),
		.m12   (m12),
		.m20   (m20),
		.m21   (m21),
		.m22   (m22)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Floor square root, one result bit per step
	function automatic longint floor_sqrt(longint n);
		longint rem, root, b;
		rem = n;
		root = 0;
		b = longint'(1) <<< 62;
		while (b > rem)
			b = b >>> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >>> 1) + b;
			end else begin
				root = root >>> 1;
			end
			b = b >>> 2;
		end
		return root;
	endfunction

	// Drop the fraction bits toward minus infinity, then clamp to 16 bits
	function automatic logic [W-1:0] scale_sat(longint v);
		longint s;
		s = v >>> FRAC;
		if (s > 32767)
			s = 32767;
		if (s < -32768)
			s = -32768;
		return s[W-1:0];
	endfunction

	// Expected matrix for one quaternion vector part
	function automatic mat_t rotation_of(logic signed [W-1:0] x, logic signed [W-1:0] y,
			logic signed [W-1:0] z);
		longint sx, sy, sz, rest, w;
		longint xx, yy, zz, xy, xz, yz, xw, yw, zw;
		mat_t m;
		sx = x;
		sy = y;
		sz = z;
		rest = UNIT_SQ - sx * sx - sy * sy - sz * sz;
		w = (rest > 0) ? floor_sqrt(rest) : 0;
		xx = 2 * sx * sx;
		yy = 2 * sy * sy;
		zz = 2 * sz * sz;
		xy = 2 * sx * sy;
		xz = 2 * sx * sz;
		yz = 2 * sy * sz;
		xw = 2 * sx * w;
		yw = 2 * sy * w;
		zw = 2 * sz * w;
		m[0] = scale_sat(UNIT_SQ - yy - zz);
		m[1] = scale_sat(xy - zw);
		m[2] = scale_sat(xz + yw);
		m[3] = scale_sat(xy + zw);
		m[4] = scale_sat(UNIT_SQ - xx - zz);
		m[5] = scale_sat(yz - xw);
		m[6] = scale_sat(xz - yw);
		m[7] = scale_sat(yz + xw);
		m[8] = scale_sat(UNIT_SQ - xx - yy);
		return m;
	endfunction

	// Check the result strobed in this cycle, then record the item accepted here
	always @(posedge clk) begin : result_check
		mat_t seen, want;
		if (arst_n && done) begin
			seen = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
			if (expected_mats.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, seen);
				errors++;
			end else begin
				want = expected_mats.pop_front();
				for (int i = 0; i < 9; i++) begin
					if (seen[i] !== want[i]) begin
						$display("%0t: %s expected %0d got %0d", $time, entry_name[i],
							$signed(want[i]), $signed(seen[i]));
						errors++;
					end
				end
			end
		end
		if (arst_n && start && !busy)
			expected_mats.push_back(rotation_of(qx, qy, qz));
	end

	// Present one item and hold it until accepted
	task automatic send_item(input logic [W-1:0] x, input logic [W-1:0] y,
			input logic [W-1:0] z);
		start <= 1'b1;
		qx <= x;
		qy <= y;
		qz <= z;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_mats.size() != 0)
			@(posedge clk);
	endtask

	// Random vector part: mostly inside the unit ball, some on its surface, some any pattern
	task automatic send_random_item();
		longint a, b, c, lim, remain;
		int kind, axis;
		logic [W-1:0] v [3];
		kind = $urandom_range(0, 99);
		if (kind >= 85) begin
			send_item(W'($urandom), W'($urandom), W'($urandom));
		end else begin
			a = longint'($urandom_range(0, 2 * ONE)) - ONE;
			remain = UNIT_SQ - a * a;
			lim = floor_sqrt(remain);
			b = longint'($urandom_range(0, 2 * lim)) - lim;
			remain = remain - b * b;
			lim = floor_sqrt(remain);
			if (kind < 60) begin
				c = longint'($urandom_range(0, 2 * lim)) - lim;
			end else begin
				// land just inside, on or just across the unit sphere
				c = lim + longint'($urandom_range(0, 2)) - 1;
				if ($urandom_range(0, 1))
					c = -c;
			end
			axis = $urandom_range(0, 2);
			v[axis] = a[W-1:0];
			v[(axis + 1) % 3] = b[W-1:0];
			v[(axis + 2) % 3] = c[W-1:0];
			send_item(v[0], v[1], v[2]);
		end
	endtask

	// Axes, signed extremes, exact unit norm, saturation and floor rounding of negatives
	task automatic test_directed();
		send_item(16'sd0, 16'sd0, 16'sd0);
		send_item(16'sd16384, 16'sd0, 16'sd0);
		send_item(16'sd0, 16'sd16384, 16'sd0);
		send_item(16'sd0, 16'sd0, 16'sd16384);
		send_item(-16'sd16384, 16'sd0, 16'sd0);
		send_item(16'sd0, -16'sd16384, 16'sd0);
		send_item(16'sd0, 16'sd0, -16'sd16384);
		send_item(16'sd8192, 16'sd8192, 16'sd8192);
		send_item(-16'sd8192, 16'sd8192, -16'sd8192);
		send_item(16'sd11585, 16'sd11585, 16'sd0);
		send_item(16'sd9459, -16'sd9459, 16'sd9459);
		send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_item(16'sh8000, 16'sh8000, 16'sh8000);
		send_item(16'sh7FFF, 16'sh8000, 16'sh0001);
		send_item(16'sh8000, 16'sd0, 16'sd0);
		send_item(16'sh7FFF, 16'sd0, 16'sd0);
		send_item(16'sd1, 16'sd0, 16'sd0);
		send_item(-16'sd1, -16'sd1, -16'sd1);
		send_item(-16'sd1, 16'sd1, 16'sd0);
		send_item(16'sd3, -16'sd5, 16'sd7);
		send_item(16'sd16385, 16'sd0, 16'sd0);
		send_item(16'sd16384, 16'sd1, 16'sd0);
	endtask

	// Random items with random idle bursts on the sender side
	task automatic test_random_with_gaps(input int n);
		for (int i = 0; i < n; i++) begin
			send_random_item();
			if ($urandom_range(0, 3) == 0)
				idle_cycles($urandom_range(1, 16));
		end
	endtask

	// Stop sending until every result is back, then resume
	task automatic test_pause_for_results();
		for (int i = 0; i < 20; i++)
			send_random_item();
		wait_drained();
		for (int i = 0; i < 20; i++)
			send_random_item();
	endtask

	// Full rate, no idling
	task automatic test_back_to_back(input int n);
		for (int i = 0; i < n; i++)
			send_random_item();
	endtask

	initial begin
		errors = 0;
		arst_n = 1'b0;
		start = 1'b0;
		qx = '0;
		qy = '0;
		qz = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_with_gaps(900);
		test_pause_for_results();
		test_back_to_back(400);

		// Drain outstanding results, then give the pipeline time to settle
		start <= 1'b0;
		for (int i = 0; i < 200 && expected_mats.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_mats.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_mats.size());
			errors++;
		end
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Hard stop if the handshake hangs
	initial begin
		#2ms;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

[rotation_matrix_from_rotation_vector_unit.f]
src/rmrv_pkg.sv
src/rmrv_isqrt.sv
src/rotation_matrix_from_rotation_vector_unit.sv
tb/rotation_matrix_from_rotation_vector_unit_tb.sv
